### rtl/core/trimmed_moving_average_top_assert.svh
// Assertion macros for the trimmed moving average block.
`ifndef TRIMMED_MOVING_AVERAGE_TOP_ASSERT_SVH
`define TRIMMED_MOVING_AVERAGE_TOP_ASSERT_SVH

`ifndef SYNTH

// expr holds at every clock edge out of reset
`define TMA_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");

// cons holds in the same cycle as ante
`define TMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`else

`define TMA_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define TMA_ASSERT_IMPLY(label, clk, rst_n, ante, cons)

`endif

`endif

### rtl/core/tma_pkg.sv
`default_nettype none

package tma_pkg;

    localparam int SAMPLE_W     = 64;
    localparam int CMD_W        = 2;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 7;
    localparam int WINDOW_RESET = 16;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DISCARD     = 2'd1;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH  = 2'd0,
        CMD_READ  = 2'd1,
        CMD_CLEAR = 2'd2
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [SAMPLE_W-1:0]  sample;
    } op_t;

    typedef struct packed {
        logic                   en;
        logic [CFG_IDX_W-1:0]   index;
        logic [CFG_DATA_W-1:0]  data;
    } cfg_wr_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_SCAN,
        B_TRIM,
        B_START,
        B_DIV,
        B_DONE
    } back_state_t;

endpackage

`default_nettype wire

### rtl/core/tma_if.sv
`default_nettype none

interface tma_item_if import tma_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CMD_W-1:0]     command;
    logic [SAMPLE_W-1:0]  sample;

    modport source (output valid, output command, output sample, input ready);
    modport sink (input valid, input command, input sample, output ready);
endinterface

interface tma_result_if import tma_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [SAMPLE_W-1:0]  average;
    logic                 empty_error;

    modport source (output valid, output average, output empty_error, input ready);
    modport sink (input valid, input average, input empty_error, output ready);
endinterface

interface tma_cfg_if import tma_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [CFG_IDX_W-1:0]   index;
    logic [CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

### rtl/core/tma_front.sv
`default_nettype none

module tma_front
    import tma_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    tma_item_if.sink   req,
    input  wire logic  q_pop,
    output logic       q_valid,
    output op_t        q_op
);

    op_t               fifo_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              accept;
    logic              known;
    logic              push;

    assign req.ready = (count_reg != QCNT_W'(QUEUE_DEPTH));
    assign accept    = req.valid && req.ready;
    assign q_valid   = (count_reg != '0);
    assign q_op      = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        case (cmd_t'(req.command))
            CMD_PUSH, CMD_READ, CMD_CLEAR: known = 1'b1;
            default:                       known = 1'b0;
        endcase
    end

    // drop the unused command code here; it has no effect downstream
    assign push = accept && known;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + QPTR_W'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !q_pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (!push && q_pop)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= '{cmd: cmd_t'(req.command), sample: req.sample};
        end
    end

endmodule

`default_nettype wire

### rtl/core/tma_div.sv
`default_nettype none

module tma_div
    import tma_pkg::*;
#(
    parameter int SUM_W = 71,
    parameter int DIV_W = 7
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire logic [SUM_W-1:0]  dividend,
    input  wire logic [DIV_W-1:0]  divisor,
    output logic                   done,
    output logic [SAMPLE_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(SUM_W);

    logic             busy_reg;
    logic             done_reg;
    logic             neg_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [SUM_W-1:0] qr_reg;
    logic [SUM_W-1:0] qr_next;
    logic [DIV_W-1:0] rem_reg;
    logic [DIV_W-1:0] rem_next;
    logic [DIV_W-1:0] d_reg;
    logic [DIV_W:0]   rem_sh;
    logic [DIV_W+1:0] diff;
    logic             ge;

    // restoring division, one quotient bit per cycle, MSB first
    assign rem_sh   = {rem_reg, qr_reg[SUM_W-1]};
    assign diff     = {1'b0, rem_sh} - {2'b00, d_reg};
    assign ge       = !diff[DIV_W+1];
    assign rem_next = ge ? diff[DIV_W-1:0] : rem_sh[DIV_W-1:0];
    assign qr_next  = {qr_reg[SUM_W-2:0], ge};

    assign done     = done_reg;
    assign quotient = neg_reg ? (~qr_reg[SAMPLE_W-1:0] + SAMPLE_W'(1))
                              : qr_reg[SAMPLE_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(SUM_W - 1);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[SUM_W-1];
            qr_reg  <= dividend[SUM_W-1] ? (~dividend + SUM_W'(1)) : dividend;
            rem_reg <= '0;
            d_reg   <= divisor;
        end
        else if (busy_reg)
        begin
            qr_reg  <= qr_next;
            rem_reg <= rem_next;
        end
    end

endmodule

`default_nettype wire

### rtl/core/tma_back.sv
`default_nettype none

module tma_back
    import tma_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire cfg_wr_t  cfg_wr,
    input  wire logic     q_valid,
    input  wire op_t      q_op,
    output logic          q_pop,
    tma_result_if.source  rsp
);

    localparam int PTR_W  = $clog2(WINDOW_MAX);
    localparam int FILL_W = $clog2(WINDOW_MAX + 1);
    localparam int SUM_W  = SAMPLE_W + PTR_W + 1;
    localparam int WS_RST = (WINDOW_MAX < WINDOW_RESET) ? WINDOW_MAX : WINDOW_RESET;

    back_state_t              state_reg;
    back_state_t              state_next;
    logic [FILL_W-1:0]        ws_reg;
    logic [FILL_W-1:0]        ws_next;
    logic                     disc_reg;
    logic                     disc_next;
    logic [PTR_W-1:0]         wp_reg;
    logic [PTR_W-1:0]         wp_next;
    logic [FILL_W-1:0]        fill_reg;
    logic [FILL_W-1:0]        fill_next;
    logic [PTR_W-1:0]         scan_addr_reg;
    logic [PTR_W-1:0]         scan_addr_next;
    logic                     issue_reg;
    logic                     issue_next;
    logic                     rd_vld_reg;
    logic [PTR_W-1:0]         acc_cnt_reg;
    logic [PTR_W-1:0]         acc_cnt_next;
    logic signed [SUM_W-1:0]  sum_reg;
    logic signed [SUM_W-1:0]  sum_next;
    logic signed [SAMPLE_W-1:0] min_reg;
    logic signed [SAMPLE_W-1:0] min_next;
    logic signed [SAMPLE_W-1:0] max_reg;
    logic signed [SAMPLE_W-1:0] max_next;
    logic [FILL_W-1:0]        div_d_reg;
    logic [FILL_W-1:0]        div_d_next;
    logic [SAMPLE_W-1:0]      pend_avg_reg;
    logic [SAMPLE_W-1:0]      pend_avg_next;
    logic                     pend_err_reg;
    logic                     pend_err_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [SAMPLE_W-1:0]      out_avg_reg;
    logic                     out_err_reg;
    logic                     out_load;
    logic [SAMPLE_W-1:0]      mem [WINDOW_MAX];
    logic signed [SAMPLE_W-1:0] rd_data_reg;
    logic                     mem_we;
    logic [FILL_W-1:0]        fill_m1;
    logic [PTR_W-1:0]         last_idx;
    logic [FILL_W-1:0]        wp_inc;
    logic [31:0]              ws_raw;
    logic                     div_start;
    logic                     div_done;
    logic [SAMPLE_W-1:0]      div_quot;

    assign fill_m1  = fill_reg - FILL_W'(1);
    assign last_idx = fill_m1[PTR_W-1:0];
    assign wp_inc   = FILL_W'(wp_reg) + FILL_W'(1);
    assign ws_raw   = {{(32 - CFG_DATA_W){1'b0}}, cfg_wr.data};
    assign out_load = (state_reg == B_DONE) && (!out_valid_reg || rsp.ready);

    assign rsp.valid       = out_valid_reg;
    assign rsp.average     = out_avg_reg;
    assign rsp.empty_error = out_err_reg;

    always_comb
    begin
        state_next     = state_reg;
        ws_next        = ws_reg;
        disc_next      = disc_reg;
        wp_next        = wp_reg;
        fill_next      = fill_reg;
        scan_addr_next = scan_addr_reg;
        issue_next     = issue_reg;
        acc_cnt_next   = acc_cnt_reg;
        sum_next       = sum_reg;
        min_next       = min_reg;
        max_next       = max_reg;
        div_d_next     = div_d_reg;
        pend_avg_next  = pend_avg_reg;
        pend_err_next  = pend_err_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        div_start      = 1'b0;

        case (state_reg)
            B_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop = 1'b1;
                    case (q_op.cmd)
                        CMD_PUSH:
                        begin
                            mem_we  = 1'b1;
                            wp_next = (wp_inc >= ws_reg) ? '0 : wp_inc[PTR_W-1:0];
                            if (fill_reg < ws_reg)
                            begin
                                fill_next = fill_reg + FILL_W'(1);
                            end
                        end
                        CMD_CLEAR:
                        begin
                            wp_next   = '0;
                            fill_next = '0;
                        end
                        CMD_READ:
                        begin
                            pend_avg_next = '0;
                            pend_err_next = 1'b0;
                            if (fill_reg == '0)
                            begin
                                pend_err_next = 1'b1;
                                state_next    = B_DONE;
                            end
                            else if (disc_reg && (fill_reg <= FILL_W'(3)))
                            begin
                                state_next = B_DONE;
                            end
                            else
                            begin
                                scan_addr_next = '0;
                                issue_next     = 1'b1;
                                acc_cnt_next   = '0;
                                sum_next       = '0;
                                state_next     = B_SCAN;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            B_SCAN:
            begin
                // issue one address per cycle; the read data is registered and returns in the next cycle
                if (issue_reg)
                begin
                    if (scan_addr_reg == last_idx)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        scan_addr_next = scan_addr_reg + PTR_W'(1);
                    end
                end
                if (rd_vld_reg)
                begin
                    sum_next = sum_reg + {{(SUM_W - SAMPLE_W){rd_data_reg[SAMPLE_W-1]}},
                                          rd_data_reg};
                    if ((acc_cnt_reg == '0) || (rd_data_reg < min_reg))
                    begin
                        min_next = rd_data_reg;
                    end
                    if ((acc_cnt_reg == '0) || (rd_data_reg > max_reg))
                    begin
                        max_next = rd_data_reg;
                    end
                    acc_cnt_next = acc_cnt_reg + PTR_W'(1);
                    if (acc_cnt_reg == last_idx)
                    begin
                        state_next = B_TRIM;
                    end
                end
            end
            B_TRIM:
            begin
                if (disc_reg)
                begin
                    sum_next = sum_reg
                             - {{(SUM_W - SAMPLE_W){min_reg[SAMPLE_W-1]}}, min_reg}
                             - {{(SUM_W - SAMPLE_W){max_reg[SAMPLE_W-1]}}, max_reg};
                    div_d_next = fill_reg - FILL_W'(2);
                end
                else
                begin
                    div_d_next = fill_reg;
                end
                state_next = B_START;
            end
            B_START:
            begin
                div_start  = 1'b1;
                state_next = B_DIV;
            end
            B_DIV:
            begin
                if (div_done)
                begin
                    pend_avg_next = div_quot;
                    pend_err_next = 1'b0;
                    state_next    = B_DONE;
                end
            end
            B_DONE:
            begin
                // hold the result until the output register is free
                if (out_load)
                begin
                    state_next = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase

        if (cfg_wr.en)
        begin
            case (cfg_wr.index)
                REG_WINDOW_SIZE:
                begin
                    if (ws_raw == 32'd0)
                    begin
                        ws_next = FILL_W'(1);
                    end
                    else if (ws_raw > 32'(WINDOW_MAX))
                    begin
                        ws_next = FILL_W'(WINDOW_MAX);
                    end
                    else
                    begin
                        ws_next = ws_raw[FILL_W-1:0];
                    end
                    wp_next   = '0;
                    fill_next = '0;
                end
                REG_DISCARD:
                begin
                    disc_next = cfg_wr.data[0];
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            ws_reg        <= FILL_W'(WS_RST);
            disc_reg      <= 1'b0;
            wp_reg        <= '0;
            fill_reg      <= '0;
            issue_reg     <= 1'b0;
            rd_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ws_reg        <= ws_next;
            disc_reg      <= disc_next;
            wp_reg        <= wp_next;
            fill_reg      <= fill_next;
            issue_reg     <= issue_next;
            rd_vld_reg    <= (state_reg == B_SCAN) && issue_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_addr_reg <= scan_addr_next;
        acc_cnt_reg   <= acc_cnt_next;
        sum_reg       <= sum_next;
        min_reg       <= min_next;
        max_reg       <= max_next;
        div_d_reg     <= div_d_next;
        pend_avg_reg  <= pend_avg_next;
        pend_err_reg  <= pend_err_next;
        if (out_load)
        begin
            out_avg_reg <= pend_avg_reg;
            out_err_reg <= pend_err_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wp_reg] <= q_op.sample;
        end
        rd_data_reg <= mem[scan_addr_reg];
    end

    tma_div #(
        .SUM_W (SUM_W),
        .DIV_W (FILL_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg),
        .divisor  (div_d_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

`default_nettype wire

### rtl/core/trimmed_moving_average_top.sv
// Trimmed moving average over the most recent signed 64-bit samples.
// Channels: req carries a command (push, read, clear) and a sample; rsp carries
// one result (average, empty_error) for each read; cfg writes window_size
// (index 0, clamped to 1..WINDOW_MAX, also empties the window) and
// discard_min_max (index 1). cfg is always ready; write it only when idle.
// A two-entry queue sits between the command decoder and the execution unit,
// so req keeps being taken while a read is in progress or a result waits.
// Push and clear are done in the idle state of the execution unit. A read
// scans the sample memory (one read port, one sample per cycle), then starts
// and runs the bit-serial divider, and then loads the result into the output
// register. A read on an empty window, or on three or fewer samples with
// min/max rejection, skips the scan and the divider. Reset empties the
// window, sets window_size to 16 (WINDOW_MAX if smaller) and turns rejection
// off; the sample memory needs no clearing pass. When rsp stalls, the result
// holds in the output register, the execution unit waits after its next
// read, and req backs up once the queue is full.
`default_nettype none

`include "trimmed_moving_average_top_assert.svh"

module trimmed_moving_average_top
    import tma_pkg::*;
#(
    parameter int WINDOW_MAX = 64
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    tma_item_if.sink      req,
    tma_result_if.source  rsp,
    tma_cfg_if.sink       cfg
);

    logic    q_valid;
    logic    q_pop;
    op_t     q_op;
    cfg_wr_t cfg_wr;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.en    = cfg.valid && cfg.ready;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    tma_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .q_pop   (q_pop),
        .q_valid (q_valid),
        .q_op    (q_op)
    );

    tma_back #(
        .WINDOW_MAX (WINDOW_MAX)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_wr  (cfg_wr),
        .q_valid (q_valid),
        .q_op    (q_op),
        .q_pop   (q_pop),
        .rsp     (rsp)
    );

    `TMA_ASSERT_IMPLY(a_pop_needs_entry, clk, rst_n, q_pop, q_valid)
    `TMA_ASSERT_IMPLY(a_stall_means_queued, clk, rst_n, !req.ready, q_valid)
    `TMA_ASSERT_IMPLY(a_error_gives_zero, clk, rst_n, rsp.valid && rsp.empty_error,
                      rsp.average == '0)

endmodule

`default_nettype wire
